// File: hw/rtl/display_damage_accumulator_assert.svh
// Assertion macros used by the checker file of the damage accumulator.
`ifndef DISPLAY_DAMAGE_ACCUMULATOR_ASSERT_SVH
`define DISPLAY_DAMAGE_ACCUMULATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define DDA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define DDA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dda_pkg;

  localparam int COORD_BITS    = 16;
  localparam int MAX_STEPS_DEF = 8;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [COORD_BITS:0]   cext_t;

  localparam cext_t SPACE_END = {1'b1, {COORD_BITS{1'b0}}};

  // Request codes.
  localparam logic [1:0] REQ_DIRTY  = 2'd0;
  localparam logic [1:0] REQ_SCROLL = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  // Result item kinds.
  localparam logic [1:0] KIND_DIRTY   = 2'd0;
  localparam logic [1:0] KIND_SCROLL  = 2'd1;
  localparam logic [1:0] KIND_ODIRTY  = 2'd2;
  localparam logic [1:0] KIND_OSCROLL = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_BX = 2'd0;
  localparam logic [1:0] CFG_BY = 2'd1;
  localparam logic [1:0] CFG_BW = 2'd2;
  localparam logic [1:0] CFG_BH = 2'd3;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef struct packed {
    logic   is_scroll;
    logic   exposed;
    coord_t rows;
    rect_t  r;
  } step_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic req_load;
    logic bnd_en;
    logic clip_en;
    logic prep_en;
    logic apply_en;
    logic wr2_en;
    logic idx_clr;
    logic idx_inc;
    logic out_ld_step;
    logic out_ld_od;
    logic out_ld_os;
    logic clear_all;
  } dda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic total_zero;
    logic idx_last;
    logic need_wr2;
  } dda_sts_t;

  function automatic logic rect_empty(rect_t a);
    return (a.w == '0) || (a.h == '0);
  endfunction

  // Intersection; nothing left gives the all-zero rectangle.
  function automatic rect_t rect_clip(rect_t a, rect_t b);
    cext_t x0, y0, x1, y1, ax1, ay1, bx1, by1, tw, th;
    rect_t z;
    x0  = (a.x > b.x) ? {1'b0, a.x} : {1'b0, b.x};
    y0  = (a.y > b.y) ? {1'b0, a.y} : {1'b0, b.y};
    ax1 = {1'b0, a.x} + {1'b0, a.w};
    bx1 = {1'b0, b.x} + {1'b0, b.w};
    ay1 = {1'b0, a.y} + {1'b0, a.h};
    by1 = {1'b0, b.y} + {1'b0, b.h};
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    tw  = x1 - x0;
    th  = y1 - y0;
    z   = '0;
    if ((x1 > x0) && (y1 > y0)) begin
      z.x = x0[COORD_BITS-1:0];
      z.y = y0[COORD_BITS-1:0];
      z.w = tw[COORD_BITS-1:0];
      z.h = th[COORD_BITS-1:0];
    end
    return z;
  endfunction

  // Bounding box; an empty operand is ignored.
  function automatic rect_t rect_union(rect_t a, rect_t b);
    cext_t ax1, ay1, bx1, by1, x1, y1, tw, th;
    rect_t z;
    ax1 = {1'b0, a.x} + {1'b0, a.w};
    bx1 = {1'b0, b.x} + {1'b0, b.w};
    ay1 = {1'b0, a.y} + {1'b0, a.h};
    by1 = {1'b0, b.y} + {1'b0, b.h};
    x1  = (ax1 > bx1) ? ax1 : bx1;
    y1  = (ay1 > by1) ? ay1 : by1;
    z.x = (a.x < b.x) ? a.x : b.x;
    z.y = (a.y < b.y) ? a.y : b.y;
    tw  = x1 - {1'b0, z.x};
    th  = y1 - {1'b0, z.y};
    z.w = tw[COORD_BITS-1:0];
    z.h = th[COORD_BITS-1:0];
    if (rect_empty(a)) begin
      z = b;
    end else if (rect_empty(b)) begin
      z = a;
    end
    return z;
  endfunction

  // Bounds clipped to the coordinate space.
  function automatic rect_t eff_bounds(coord_t bx, coord_t by, coord_t bw, coord_t bh);
    cext_t ex, ey, rw, rh;
    rect_t z;
    ex = {1'b0, bx} + {1'b0, bw};
    ey = {1'b0, by} + {1'b0, bh};
    rw = SPACE_END - {1'b0, bx};
    rh = SPACE_END - {1'b0, by};
    z  = '0;
    if ((bw != '0) && (bh != '0)) begin
      z.x = bx;
      z.y = by;
      z.w = (ex > SPACE_END) ? rw[COORD_BITS-1:0] : bw;
      z.h = (ey > SPACE_END) ? rh[COORD_BITS-1:0] : bh;
    end
    return z;
  endfunction

  // Bottom strip of height d that an upward scroll exposes; the whole r when d >= r.h.
  function automatic rect_t strip_of(rect_t r, cext_t d);
    cext_t ny;
    rect_t z;
    ny = {1'b0, r.y} + {1'b0, r.h} - d;
    z  = r;
    if (d < {1'b0, r.h}) begin
      z.y = ny[COORD_BITS-1:0];
      z.h = d[COORD_BITS-1:0];
    end
    return z;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/dda_if.sv
`timescale 1ns / 1ps
`default_nettype none

// Request channel.
interface dda_in_if import dda_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  coord_t     rect_x;
  coord_t     rect_y;
  coord_t     rect_w;
  coord_t     rect_h;
  coord_t     distance;

  modport source (output valid, req_type, rect_x, rect_y, rect_w, rect_h, distance,
                  input ready);
  modport sink (input valid, req_type, rect_x, rect_y, rect_w, rect_h, distance,
                output ready);
endinterface

// Result channel.
interface dda_out_if import dda_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] item_kind;
  logic       item_valid;
  coord_t     out_x;
  coord_t     out_y;
  coord_t     out_w;
  coord_t     out_h;
  coord_t     out_distance;
  logic       exposed_by_scroll;
  logic       last;

  modport source (output valid, item_kind, item_valid, out_x, out_y, out_w, out_h,
                  out_distance, exposed_by_scroll, last, input ready);
  modport sink (input valid, item_kind, item_valid, out_x, out_y, out_w, out_h,
                out_distance, exposed_by_scroll, last, output ready);
endinterface

// Configuration write channel.
interface dda_cfg_if import dda_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  coord_t     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/display_damage_accumulator.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Handshake      Payload
// in_ch    in   valid/ready    req_type, rect_x, rect_y, rect_w, rect_h, distance
// out_ch   out  valid/ready    item_kind, item_valid, out_x..out_h, out_distance,
//                              exposed_by_scroll, last
// cfg_ch   in   valid/ready    index, data (always ready)
//
// A dirty or scroll word passes through the bounds, clip, prepare and apply stages
// and, when it edits two steps, a second write on the single step memory write port.
// A flush reads each step through a registered memory read into the output word, then
// offers the two totals, and holds while the result side stalls. One word is in work
// at a time; the input is not ready until it is done. Reset is synchronous and
// clears all pending damage.

module display_damage_accumulator import dda_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dda_in_if.sink    in_ch,
  dda_out_if.source out_ch,
  dda_cfg_if.sink   cfg_ch
);

  dda_cmd_t cmd;
  dda_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  dda_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .out_ready   (out_ch.ready),
    .sts         (sts),
    .cmd         (cmd),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid)
  );

  dda_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_ch.valid),
    .cfg_index      (cfg_ch.index),
    .cfg_data       (cfg_ch.data),
    .in_req_type    (in_ch.req_type),
    .in_rect_x      (in_ch.rect_x),
    .in_rect_y      (in_ch.rect_y),
    .in_rect_w      (in_ch.rect_w),
    .in_rect_h      (in_ch.rect_h),
    .in_distance    (in_ch.distance),
    .cmd            (cmd),
    .sts            (sts),
    .out_item_kind  (out_ch.item_kind),
    .out_item_valid (out_ch.item_valid),
    .out_x          (out_ch.out_x),
    .out_y          (out_ch.out_y),
    .out_w          (out_ch.out_w),
    .out_h          (out_ch.out_h),
    .out_distance   (out_ch.out_distance),
    .out_exposed    (out_ch.exposed_by_scroll),
    .out_last       (out_ch.last)
  );

endmodule

`default_nettype wire

// File: hw/rtl/dda_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/dda_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_ctrl import dda_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_req_type,
  input  wire logic       out_ready,
  input  wire dda_sts_t   sts,
  output dda_cmd_t        cmd,
  output logic            in_ready,
  output logic            out_valid
);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b0000_0000_0001,
    S_BND   = 12'b0000_0000_0010,
    S_CLIP  = 12'b0000_0000_0100,
    S_PREP  = 12'b0000_0000_1000,
    S_APPLY = 12'b0000_0001_0000,
    S_WR2   = 12'b0000_0010_0000,
    S_FL_RD = 12'b0000_0100_0000,
    S_FL_LD = 12'b0000_1000_0000,
    S_FL_WS = 12'b0001_0000_0000,
    S_FL_LD_OD = 12'b0010_0000_0000,
    S_FL_W_OD  = 12'b0100_0000_0000,
    S_FL_W_OS  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  // Sequencer: update items run bounds, clip, prepare, apply and an optional
  // second memory write; a flush walks the steps and then the two totals.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.req_load = 1'b1;
          unique case (in_req_type)
            REQ_DIRTY, REQ_SCROLL: state_nxt = S_BND;
            REQ_FLUSH: begin
              cmd.idx_clr = 1'b1;
              state_nxt   = sts.total_zero ? S_FL_LD_OD : S_FL_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_BND: begin
        cmd.bnd_en = 1'b1;
        state_nxt  = S_CLIP;
      end
      S_CLIP: begin
        cmd.clip_en = 1'b1;
        state_nxt   = S_PREP;
      end
      S_PREP: begin
        cmd.prep_en = 1'b1;
        state_nxt   = S_APPLY;
      end
      S_APPLY: begin
        cmd.apply_en = 1'b1;
        state_nxt    = sts.need_wr2 ? S_WR2 : S_IDLE;
      end
      S_WR2: begin
        cmd.wr2_en = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FL_RD: state_nxt = S_FL_LD;
      S_FL_LD: begin
        cmd.out_ld_step = 1'b1;
        state_nxt       = S_FL_WS;
      end
      S_FL_WS: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.idx_last) begin
            state_nxt = S_FL_LD_OD;
          end else begin
            cmd.idx_inc = 1'b1;
            state_nxt   = S_FL_RD;
          end
        end
      end
      S_FL_LD_OD: begin
        cmd.out_ld_od = 1'b1;
        state_nxt     = S_FL_W_OD;
      end
      S_FL_W_OD: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.out_ld_os = 1'b1;
          state_nxt     = S_FL_W_OS;
        end
      end
      S_FL_W_OS: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.clear_all = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dda_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module dda_datapath import dda_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic [1:0] cfg_index,
  input  wire coord_t     cfg_data,
  input  wire logic [1:0] in_req_type,
  input  wire coord_t     in_rect_x,
  input  wire coord_t     in_rect_y,
  input  wire coord_t     in_rect_w,
  input  wire coord_t     in_rect_h,
  input  wire coord_t     in_distance,
  input  wire dda_cmd_t   cmd,
  output dda_sts_t        sts,
  output logic [1:0]      out_item_kind,
  output logic            out_item_valid,
  output coord_t          out_x,
  output coord_t          out_y,
  output coord_t          out_w,
  output coord_t          out_h,
  output coord_t          out_distance,
  output logic            out_exposed,
  output logic            out_last
);

  localparam int IW = $clog2(MAX_STEPS);
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int SW = $bits(step_t);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_STEPS);
  localparam logic [CW-1:0] ONE     = CW'(1);
  localparam logic [CW-1:0] TWO     = CW'(2);

  // Configuration registers.
  coord_t bx_r, by_r, bw_r, bh_r;

  // Request and stage registers.
  logic [1:0] rtype_r;
  rect_t      rq_r, eb_r, cr_r;
  coord_t     rd_r;
  cext_t      tot_r, ldsum_r;
  coord_t     osd_sat_r;
  rect_t      strip_d_r, strip_t_r;
  logic       big_d_r, tot_ge_r, ld_ge_r, same_p_r, same_l_r, same_os_r, noop_r;

  // Accumulated damage state; last_r and prev_r mirror the two tail steps.
  logic [CW-1:0] total_r, total_nxt;
  step_t         last_r, last_nxt, prev_r, prev_nxt;
  rect_t         od_r, od_nxt, osr_r, osr_nxt;
  coord_t        osd_r, osd_nxt;
  logic          fb_r, fb_nxt;

  // Second write of a two-step update.
  logic [IW-1:0] wr2_addr_r, wr2_addr_nxt;
  step_t         wr2_data_r, wr2_data_nxt;

  logic [IW-1:0] idx_r;

  // Memory port.
  logic          we1;
  logic [IW-1:0] addr1;
  step_t         data1;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  step_t         ram_wdata;
  logic [SW-1:0] ram_rdata;
  step_t         rd_step;

  // Apply-stage helpers.
  logic          need_wr2;
  logic          is_dirty, tot_gt0, tot_ge2, full, full1, expmerge, held, merge_l, fall;
  logic [CW-1:0] tm1, tm2, tp1;
  rect_t         od_opnd, od_u, fall_rect;
  step_t         stp_a, stp_b;

  // Bounds register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bx_r <= '0;
      by_r <= '0;
      bw_r <= '0;
      bh_r <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_BX: bx_r <= cfg_data;
        CFG_BY: by_r <= cfg_data;
        CFG_BW: bw_r <= cfg_data;
        CFG_BH: bh_r <= cfg_data;
        default: bx_r <= bx_r;
      endcase
    end
  end

  // Request capture, bounds, clip and preparation stages.
  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      rtype_r   <= in_req_type;
      rq_r.x    <= in_rect_x;
      rq_r.y    <= in_rect_y;
      rq_r.w    <= in_rect_w;
      rq_r.h    <= in_rect_h;
      rd_r      <= in_distance;
    end
    if (cmd.bnd_en) begin
      eb_r <= eff_bounds(bx_r, by_r, bw_r, bh_r);
    end
    if (cmd.clip_en) begin
      cr_r <= rect_clip(eb_r, rq_r);
    end
    if (cmd.prep_en) begin
      tot_r     <= {1'b0, prev_r.rows} + {1'b0, rd_r};
      ldsum_r   <= {1'b0, last_r.rows} + {1'b0, rd_r};
      osd_sat_r <= (({1'b0, osd_r} + {1'b0, rd_r}) > {1'b0, {COORD_BITS{1'b1}}}) ?
                   {COORD_BITS{1'b1}} : (osd_r + rd_r);
      strip_d_r <= strip_of(cr_r, {1'b0, rd_r});
      strip_t_r <= strip_of(cr_r, {1'b0, prev_r.rows} + {1'b0, rd_r});
      big_d_r   <= (rd_r >= cr_r.h);
      tot_ge_r  <= (({1'b0, prev_r.rows} + {1'b0, rd_r}) >= {1'b0, cr_r.h});
      ld_ge_r   <= (({1'b0, last_r.rows} + {1'b0, rd_r}) >= {1'b0, cr_r.h});
      same_p_r  <= (prev_r.r == cr_r);
      same_l_r  <= (last_r.r == cr_r);
      same_os_r <= (osr_r == cr_r);
      noop_r    <= rect_empty(cr_r) || ((rtype_r == REQ_SCROLL) && (rd_r == '0));
    end
  end

  // Apply stage: decide the step edits, the totals and the memory writes.
  always_comb begin
    is_dirty  = (rtype_r == REQ_DIRTY);
    tot_gt0   = (total_r != '0);
    tot_ge2   = (total_r >= TWO);
    full      = (total_r >= MAX_CNT);
    tp1       = total_r + ONE;
    full1     = (tp1 >= MAX_CNT);
    tm1       = total_r - ONE;
    tm2       = total_r - TWO;
    expmerge  = tot_ge2 && prev_r.is_scroll && !last_r.is_scroll && last_r.exposed &&
                same_p_r;
    held      = !rect_empty(osr_r) && (osd_r != '0);
    merge_l   = tot_gt0 && last_r.is_scroll && same_l_r;
    if (is_dirty) begin
      od_opnd = cr_r;
    end else if (fb_r) begin
      od_opnd = eb_r;
    end else if (expmerge) begin
      od_opnd = strip_t_r;
    end else begin
      od_opnd = strip_d_r;
    end
    od_u = rect_union(od_r, od_opnd);

    total_nxt    = total_r;
    last_nxt     = last_r;
    prev_nxt     = prev_r;
    od_nxt       = od_r;
    osr_nxt      = osr_r;
    osd_nxt      = osd_r;
    fb_nxt       = fb_r;
    wr2_addr_nxt = wr2_addr_r;
    wr2_data_nxt = wr2_data_r;
    need_wr2     = 1'b0;
    we1          = 1'b0;
    addr1        = '0;
    data1        = '0;
    fall         = 1'b0;
    fall_rect    = eb_r;
    stp_a        = '0;
    stp_b        = '0;

    if (!noop_r) begin
      if (fb_r) begin
        // Fallback: one full dirty step that keeps widening.
        od_nxt    = od_u;
        stp_a.r   = od_u;
        we1       = 1'b1;
        data1     = stp_a;
        total_nxt = ONE;
        last_nxt  = stp_a;
      end else if (is_dirty) begin
        od_nxt = od_u;
        if (tot_gt0 && !last_r.is_scroll) begin
          stp_a.r       = rect_union(last_r.r, cr_r);
          we1           = 1'b1;
          addr1         = tm1[IW-1:0];
          data1         = stp_a;
          last_nxt      = stp_a;
        end else if (!full) begin
          stp_a.r   = cr_r;
          we1       = 1'b1;
          addr1     = total_r[IW-1:0];
          data1     = stp_a;
          prev_nxt  = last_r;
          last_nxt  = stp_a;
          total_nxt = tp1;
        end else begin
          fall = 1'b1;
        end
      end else if (big_d_r) begin
        fall      = 1'b1;
        fall_rect = cr_r;
      end else if (expmerge) begin
        // Repeated scroll right after a scroll and exposed-strip pair.
        if (tot_ge_r) begin
          fall      = 1'b1;
          fall_rect = cr_r;
        end else begin
          stp_a         = prev_r;
          stp_a.rows    = tot_r[COORD_BITS-1:0];
          stp_b.exposed = 1'b1;
          stp_b.r       = strip_t_r;
          we1           = 1'b1;
          addr1         = tm2[IW-1:0];
          data1         = stp_a;
          need_wr2      = 1'b1;
          wr2_addr_nxt  = tm1[IW-1:0];
          wr2_data_nxt  = stp_b;
          prev_nxt      = stp_a;
          last_nxt      = stp_b;
          osr_nxt       = cr_r;
          osd_nxt       = tot_r[COORD_BITS-1:0];
          od_nxt        = od_u;
        end
      end else begin
        // Overall scroll tracking.
        if (held && same_os_r) begin
          osd_nxt = osd_sat_r;
        end else if (!held) begin
          osr_nxt = cr_r;
          osd_nxt = rd_r;
        end else begin
          osr_nxt = '0;
          osd_nxt = '0;
        end
        od_nxt        = od_u;
        stp_b.exposed = 1'b1;
        stp_b.r       = strip_d_r;
        if (merge_l) begin
          if (ld_ge_r || full) begin
            fall = 1'b1;
          end else begin
            stp_a        = last_r;
            stp_a.rows   = ldsum_r[COORD_BITS-1:0];
            we1          = 1'b1;
            addr1        = tm1[IW-1:0];
            data1        = stp_a;
            need_wr2     = 1'b1;
            wr2_addr_nxt = total_r[IW-1:0];
            wr2_data_nxt = stp_b;
            prev_nxt     = stp_a;
            last_nxt     = stp_b;
            total_nxt    = tp1;
          end
        end else if (full || full1) begin
          fall = 1'b1;
        end else begin
          stp_a.is_scroll = 1'b1;
          stp_a.rows      = rd_r;
          stp_a.r         = cr_r;
          we1             = 1'b1;
          addr1           = total_r[IW-1:0];
          data1           = stp_a;
          need_wr2        = 1'b1;
          wr2_addr_nxt    = tp1[IW-1:0];
          wr2_data_nxt    = stp_b;
          prev_nxt        = stp_a;
          last_nxt        = stp_b;
          total_nxt       = tp1 + ONE;
        end
      end

      // Fallback replaces everything with one full dirty step.
      if (fall) begin
        stp_a        = '0;
        stp_a.r      = fall_rect;
        we1          = 1'b1;
        addr1        = '0;
        data1        = stp_a;
        need_wr2     = 1'b0;
        total_nxt    = ONE;
        last_nxt     = stp_a;
        fb_nxt       = 1'b1;
        od_nxt       = fall_rect;
        osr_nxt      = '0;
        osd_nxt      = '0;
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
      od_r    <= '0;
      osr_r   <= '0;
      osd_r   <= '0;
      fb_r    <= 1'b0;
    end else if (cmd.clear_all) begin
      total_r <= '0;
      od_r    <= '0;
      osr_r   <= '0;
      osd_r   <= '0;
      fb_r    <= 1'b0;
    end else if (cmd.apply_en) begin
      total_r <= total_nxt;
      od_r    <= od_nxt;
      osr_r   <= osr_nxt;
      osd_r   <= osd_nxt;
      fb_r    <= fb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply_en) begin
      last_r     <= last_nxt;
      prev_r     <= prev_nxt;
      wr2_addr_r <= wr2_addr_nxt;
      wr2_data_r <= wr2_data_nxt;
    end
  end

  // Flush read index.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.idx_clr) begin
      idx_r <= '0;
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign sts.total_zero = (total_r == '0);
  assign sts.idx_last   = (CW'(idx_r) == tm1);
  assign sts.need_wr2   = need_wr2;

  // Step memory.
  assign ram_we    = (cmd.apply_en && we1) || cmd.wr2_en;
  assign ram_waddr = cmd.wr2_en ? wr2_addr_r : addr1;
  assign ram_wdata = cmd.wr2_en ? wr2_data_r : data1;

  dda_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_STEPS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign rd_step = step_t'(ram_rdata);

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.out_ld_step) begin
      out_item_kind  <= rd_step.is_scroll ? KIND_SCROLL : KIND_DIRTY;
      out_item_valid <= !rect_empty(rd_step.r) &&
                        (!rd_step.is_scroll || (rd_step.rows != '0));
      out_x          <= rd_step.r.x;
      out_y          <= rd_step.r.y;
      out_w          <= rd_step.r.w;
      out_h          <= rd_step.r.h;
      out_distance   <= rd_step.is_scroll ? rd_step.rows : '0;
      out_exposed    <= !rd_step.is_scroll && rd_step.exposed;
      out_last       <= 1'b0;
    end else if (cmd.out_ld_od) begin
      out_item_kind  <= KIND_ODIRTY;
      out_item_valid <= !rect_empty(od_r);
      out_x          <= od_r.x;
      out_y          <= od_r.y;
      out_w          <= od_r.w;
      out_h          <= od_r.h;
      out_distance   <= '0;
      out_exposed    <= 1'b0;
      out_last       <= 1'b0;
    end else if (cmd.out_ld_os) begin
      out_item_kind  <= KIND_OSCROLL;
      out_item_valid <= !rect_empty(osr_r) && (osd_r != '0);
      out_x          <= osr_r.x;
      out_y          <= osr_r.y;
      out_w          <= osr_r.w;
      out_h          <= osr_r.h;
      out_distance   <= osd_r;
      out_exposed    <= 1'b0;
      out_last       <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/dda_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "display_damage_accumulator_assert.svh"

module dda_checker import dda_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [1:0] in_req_type,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_last
);

  // A stalled result word stays offered.
  `DDA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result word dropped")

  // No request is taken while a result word is offered.
  `DDA_ASSERT_IMP(a_no_overlap, out_valid, !in_ready, "request taken during flush output")

  // The memory read state, or the total load state when no step is held, keeps the first flush word off the next cycle.
  `DDA_ASSERT_NXT(a_flush_lat, in_valid && in_ready && (in_req_type == REQ_FLUSH),
                  !out_valid, "flush word offered too early")

  // Nothing follows the last word of a flush.
  `DDA_ASSERT_NXT(a_after_last, out_valid && out_ready && out_last, !out_valid,
                  "word offered after last")

endmodule

bind display_damage_accumulator dda_checker u_dda_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_req_type (in_ch.req_type),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_last    (out_ch.last)
);

`default_nettype wire
